// ----- design/comrf_pkg.sv -----
// shared types and constants for the clock offset min-rtt filter
package comrf_pkg;

   localparam int SAMPLE_SLOTS_DEF = 16;
   localparam int MIN_PICKED_DEF   = 2;
   localparam int TS_W             = 32;
   localparam int HELD_W           = 5;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_EVAL,
      ST_SCAN,
      ST_DIV_LOAD,
      ST_DIV,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic load;
      logic read;
      logic eval;
      logic scan;
      logic div_start;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic replace;
      logic last_slot;
      logic all_read;
      logic scan_last;
      logic div_done;
   } sts_type;

endpackage

// ----- design/comrf_divider.sv -----
// bit-serial signed divider, truncating toward zero
module comrf_divider
   import comrf_pkg::*;
#(
   parameter int SUM_W = 37,
   parameter int DIV_W = 3
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [SUM_W-1:0] dividend,
   input  logic        [DIV_W-1:0] divisor,
   output logic                    done,
   output logic signed [TS_W-1:0]  quotient
);

   localparam int STEP_W = $clog2(SUM_W + 1);

   logic [SUM_W-1:0]  quot_ff, quot_in;
   logic [DIV_W-1:0]  rem_ff, rem_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [DIV_W:0]    trial;
   logic              qbit;

   always_comb begin
      quot_in = quot_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      trial   = {rem_ff, quot_ff[SUM_W-1]};
      qbit    = 1'b0;
      if (start) begin
         neg_in  = dividend[SUM_W-1];
         quot_in = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
         rem_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            qbit   = 1'b1;
            rem_in = DIV_W'(trial - {1'b0, divisor});
         end else begin
            rem_in = DIV_W'(trial);
         end
         quot_in = {quot_ff[SUM_W-2:0], qbit};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(SUM_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = TS_W'(neg_ff ? (~quot_ff + 1'b1) : quot_ff);

endmodule

// ----- design/comrf_datapath.sv -----
// sample ring, pick registers, running sum and result registers
module comrf_datapath
   import comrf_pkg::*;
#(
   parameter int SAMPLE_SLOTS = SAMPLE_SLOTS_DEF,
   parameter int MIN_PICKED   = MIN_PICKED_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output sts_type                sts,
   input  logic [TS_W-1:0]        req_ping_sent_local,
   input  logic [TS_W-1:0]        req_ping_seen_remote,
   input  logic [TS_W-1:0]        req_pong_sent_remote,
   input  logic [TS_W-1:0]        req_pong_seen_local,
   output logic signed [TS_W-1:0] rsp_offset_estimate,
   output logic [TS_W-1:0]        rsp_this_round_trip,
   output logic signed [TS_W-1:0] rsp_this_offset,
   output logic [HELD_W-1:0]      rsp_samples_held
);

   localparam int PICK_MAX = (SAMPLE_SLOTS / 4 > MIN_PICKED) ? SAMPLE_SLOTS / 4 : MIN_PICKED;
   localparam int PICK_N   = (PICK_MAX < SAMPLE_SLOTS) ? PICK_MAX : SAMPLE_SLOTS;
   localparam int PICK_W   = $clog2(PICK_MAX + 1);
   localparam int PIDX_W   = (PICK_N > 1) ? $clog2(PICK_N) : 1;
   localparam int SLOT_W   = $clog2(SAMPLE_SLOTS);
   localparam int CNT_W    = $clog2(SAMPLE_SLOTS + 1);
   localparam int SUM_W    = TS_W + $clog2(PICK_N + 1);

   // slot store
   logic [TS_W-1:0]        slot_rtt_mem [SAMPLE_SLOTS];
   logic signed [TS_W-1:0] slot_off_mem [SAMPLE_SLOTS];
   logic [TS_W-1:0]        rd_rtt_ff;
   logic signed [TS_W-1:0] rd_off_ff;

   // pick members
   logic [TS_W-1:0]        pick_rtt_ff [PICK_N];
   logic signed [TS_W-1:0] pick_off_ff [PICK_N];

   logic [SLOT_W-1:0]      write_slot_ff, write_slot_in;
   logic [CNT_W-1:0]       valid_ff, valid_in;
   logic [CNT_W-1:0]       i_ff, i_in;
   logic [PICK_W-1:0]      want_ff, want_in;
   logic [PICK_W-1:0]      cnt_ff, cnt_in;
   logic [PIDX_W-1:0]      j_ff, j_in;
   logic [PIDX_W-1:0]      top_pos_ff, top_pos_in;
   logic [TS_W-1:0]        top_rtt_ff, top_rtt_in;
   logic signed [SUM_W-1:0] sum_ff, sum_in;
   logic [TS_W-1:0]        this_rtt_ff, this_rtt_in;
   logic signed [TS_W-1:0] this_off_ff, this_off_in;
   logic signed [TS_W-1:0] estimate_ff, estimate_in;

   logic [TS_W-1:0]        leg1, leg2;
   logic signed [TS_W:0]   leg_sum;
   logic signed [TS_W:0]   leg_adj;
   logic                   fill;
   logic                   replace;
   logic [PIDX_W-1:0]      cnt_idx;
   logic                   div_done;
   logic signed [TS_W-1:0] div_quot;

   assign cnt_idx = cnt_ff[PIDX_W-1:0];
   assign fill    = cnt_ff < want_ff;
   assign replace = !fill && (rd_rtt_ff < top_rtt_ff);

   assign leg1    = req_ping_seen_remote - req_ping_sent_local;
   assign leg2    = req_pong_sent_remote - req_pong_seen_local;
   assign leg_sum = (TS_W + 1)'(signed'(leg1)) + (TS_W + 1)'(signed'(leg2));
   // odd negative sums round toward zero
   assign leg_adj = leg_sum + (TS_W + 1)'(leg_sum[TS_W]);

   always_comb begin
      write_slot_in = write_slot_ff;
      valid_in      = valid_ff;
      i_in          = i_ff;
      want_in       = want_ff;
      cnt_in        = cnt_ff;
      j_in          = j_ff;
      top_pos_in    = top_pos_ff;
      top_rtt_in    = top_rtt_ff;
      sum_in        = sum_ff;
      this_rtt_in   = this_rtt_ff;
      this_off_in   = this_off_ff;
      estimate_in   = estimate_ff;

      if (cmd.load) begin
         this_rtt_in = req_pong_seen_local - req_ping_sent_local
                     - (req_pong_sent_remote - req_ping_seen_remote);
         this_off_in = leg_adj[TS_W:1];
         if (valid_ff != CNT_W'(SAMPLE_SLOTS)) begin
            valid_in = valid_ff + 1'b1;
         end
         if (write_slot_ff == SLOT_W'(SAMPLE_SLOTS - 1)) begin
            write_slot_in = '0;
         end else begin
            write_slot_in = write_slot_ff + 1'b1;
         end
         if (int'(valid_in >> 2) < MIN_PICKED) begin
            want_in = PICK_W'(MIN_PICKED);
         end else begin
            want_in = PICK_W'(valid_in >> 2);
         end
         i_in   = '0;
         cnt_in = '0;
      end

      if (cmd.eval) begin
         i_in = i_ff + 1'b1;
         if (fill) begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == '0) begin
               sum_in     = SUM_W'(rd_off_ff);
               top_rtt_in = rd_rtt_ff;
               top_pos_in = '0;
            end else begin
               sum_in = sum_ff + SUM_W'(rd_off_ff);
               if (rd_rtt_ff > top_rtt_ff) begin
                  top_rtt_in = rd_rtt_ff;
                  top_pos_in = cnt_idx;
               end
            end
         end else if (replace) begin
            sum_in     = sum_ff - SUM_W'(pick_off_ff[top_pos_ff]) + SUM_W'(rd_off_ff);
            top_rtt_in = rd_rtt_ff;
            j_in       = '0;
         end
      end

      // rescan keeps the replaced position unless a member lies strictly above
      if (cmd.scan) begin
         j_in = j_ff + 1'b1;
         if (pick_rtt_ff[j_ff] > top_rtt_ff) begin
            top_rtt_in = pick_rtt_ff[j_ff];
            top_pos_in = j_ff;
         end
      end

      if (cmd.finish) begin
         estimate_in = div_quot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         write_slot_ff <= '0;
         valid_ff      <= '0;
         i_ff          <= '0;
         want_ff       <= '0;
         cnt_ff        <= '0;
         j_ff          <= '0;
         top_pos_ff    <= '0;
         estimate_ff   <= '0;
      end else begin
         write_slot_ff <= write_slot_in;
         valid_ff      <= valid_in;
         i_ff          <= i_in;
         want_ff       <= want_in;
         cnt_ff        <= cnt_in;
         j_ff          <= j_in;
         top_pos_ff    <= top_pos_in;
         estimate_ff   <= estimate_in;
      end
   end

   always_ff @(posedge clock) begin
      top_rtt_ff  <= top_rtt_in;
      sum_ff      <= sum_in;
      this_rtt_ff <= this_rtt_in;
      this_off_ff <= this_off_in;
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         slot_rtt_mem[write_slot_ff] <= this_rtt_in;
         slot_off_mem[write_slot_ff] <= this_off_in;
      end
      if (cmd.read) begin
         rd_rtt_ff <= slot_rtt_mem[i_ff[SLOT_W-1:0]];
         rd_off_ff <= slot_off_mem[i_ff[SLOT_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.eval) begin
         if (fill) begin
            pick_rtt_ff[cnt_idx] <= rd_rtt_ff;
            pick_off_ff[cnt_idx] <= rd_off_ff;
         end else if (replace) begin
            pick_rtt_ff[top_pos_ff] <= rd_rtt_ff;
            pick_off_ff[top_pos_ff] <= rd_off_ff;
         end
      end
   end

   comrf_divider #(
      .SUM_W (SUM_W),
      .DIV_W (PICK_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (sum_ff),
      .divisor  (cnt_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   always_comb begin
      sts.replace   = replace;
      sts.last_slot = (CNT_W'(i_ff + 1'b1) == valid_ff);
      sts.all_read  = (i_ff == valid_ff);
      sts.scan_last = (PICK_W'(j_ff) == PICK_W'(cnt_ff - 1'b1));
      sts.div_done  = div_done;
   end

   assign rsp_offset_estimate = estimate_ff;
   assign rsp_this_round_trip = this_rtt_ff;
   assign rsp_this_offset     = this_off_ff;
   assign rsp_samples_held    = HELD_W'(valid_ff);

endmodule

// ----- design/comrf_ctrl.sv -----
// sequencer for insert, slot scan, rescan, divide and response
module comrf_ctrl
   import comrf_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (sts.replace) begin
               state_in = ST_SCAN;
            end else if (sts.last_slot) begin
               state_in = ST_DIV_LOAD;
            end else begin
               state_in = ST_READ;
            end
         end
         ST_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = sts.all_read ? ST_DIV_LOAD : ST_READ;
            end
         end
         ST_DIV_LOAD: begin
            cmd.div_start = 1'b1;
            state_in      = ST_DIV;
         end
         ST_DIV: begin
            if (sts.div_done) begin
               cmd.finish = 1'b1;
               state_in   = ST_RESP;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- design/clock_offset_min_rtt_filter.sv -----
// Clock offset filter: each item of four ping/pong timestamps yields one result with this
// sample's round trip and offset, the number of held samples, and the truncated mean offset of
// the lowest-round-trip quarter (at least MIN_PICKED) of the ring of SAMPLE_SLOTS samples. One
// item is in work at a time. The time an item takes is set by the single read port of the slot
// store, the one-member-per-cycle rescan of the pick after each replacement and the bit-serial
// divider. The slot store needs no clearing pass: only written slots are ever read.
module clock_offset_min_rtt_filter
   import comrf_pkg::*;
#(
   parameter int SAMPLE_SLOTS = SAMPLE_SLOTS_DEF,
   parameter int MIN_PICKED   = MIN_PICKED_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [TS_W-1:0]        req_ping_sent_local,
   input  logic [TS_W-1:0]        req_ping_seen_remote,
   input  logic [TS_W-1:0]        req_pong_sent_remote,
   input  logic [TS_W-1:0]        req_pong_seen_local,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic signed [TS_W-1:0] rsp_offset_estimate,
   output logic [TS_W-1:0]        rsp_this_round_trip,
   output logic signed [TS_W-1:0] rsp_this_offset,
   output logic [HELD_W-1:0]      rsp_samples_held
);

   cmd_type cmd;
   sts_type sts;

   comrf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   comrf_datapath #(
      .SAMPLE_SLOTS (SAMPLE_SLOTS),
      .MIN_PICKED   (MIN_PICKED)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_ping_sent_local  (req_ping_sent_local),
      .req_ping_seen_remote (req_ping_seen_remote),
      .req_pong_sent_remote (req_pong_sent_remote),
      .req_pong_seen_local  (req_pong_seen_local),
      .rsp_offset_estimate  (rsp_offset_estimate),
      .rsp_this_round_trip  (rsp_this_round_trip),
      .rsp_this_offset      (rsp_this_offset),
      .rsp_samples_held     (rsp_samples_held)
   );

endmodule

// ----- design/comrf_checker.sv -----
// port-level checks for the clock offset filter, bound to the top level
module comrf_checker
   import comrf_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic [TS_W-1:0]        req_ping_sent_local,
   input logic [TS_W-1:0]        req_ping_seen_remote,
   input logic [TS_W-1:0]        req_pong_sent_remote,
   input logic [TS_W-1:0]        req_pong_seen_local,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic signed [TS_W-1:0] rsp_offset_estimate,
   input logic [TS_W-1:0]        rsp_this_round_trip,
   input logic signed [TS_W-1:0] rsp_this_offset,
   input logic [HELD_W-1:0]      rsp_samples_held
);

   // a waiting result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_offset_estimate)
         && $stable(rsp_this_round_trip) && $stable(rsp_this_offset)
         && $stable(rsp_samples_held))
      else $error("result changed while stalled");

   // an accepted item blocks the input until its result is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall && !rsp_valid)
      else $error("input open or result shown right after accept");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result waits");

   // exactly one result per item
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("second result for one item");

endmodule

bind clock_offset_min_rtt_filter comrf_checker u_checker (.*);

// ----- tb/tb_clock_offset_min_rtt_filter.sv -----
// testbench for the clock offset min-rtt filter: directed, backpressure and random exchanges
`timescale 1ns / 1ps

module tb_clock_offset_min_rtt_filter;
   import comrf_pkg::*;

   localparam int SLOTS       = SAMPLE_SLOTS_DEF;
   localparam int MIN_PICK    = MIN_PICKED_DEF;
   localparam int CYCLE_LIMIT = 1_000_000;
   localparam int SETTLE      = 200;
   localparam int MAX_PRINTS  = 40;

   typedef logic [TS_W-1:0] ts_type;

   typedef struct packed {
      ts_type            estimate;
      ts_type            round_trip;
      ts_type            offset;
      logic [HELD_W-1:0] held;
   } exchange_result_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   ts_type            req_ping_sent_local = '0;
   ts_type            req_ping_seen_remote = '0;
   ts_type            req_pong_sent_remote = '0;
   ts_type            req_pong_seen_local = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic signed [TS_W-1:0] rsp_offset_estimate;
   ts_type            rsp_this_round_trip;
   logic signed [TS_W-1:0] rsp_this_offset;
   logic [HELD_W-1:0] rsp_samples_held;

   // predictor copy of the sample ring
   ts_type ring_rtt [SLOTS];
   ts_type ring_off [SLOTS];
   int  ring_wr = 0;
   int  ring_count = 0;

   exchange_result_type expected_results [$];
   int mismatches = 0;
   int cycle_count = 0;
   int tx_idle_pct = 0;
   int rx_busy_pct = 0;
   int hold_request = 0;

   clock_offset_min_rtt_filter u_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_ping_sent_local  (req_ping_sent_local),
      .req_ping_seen_remote (req_ping_seen_remote),
      .req_pong_sent_remote (req_pong_sent_remote),
      .req_pong_seen_local  (req_pong_seen_local),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_offset_estimate  (rsp_offset_estimate),
      .rsp_this_round_trip  (rsp_this_round_trip),
      .rsp_this_offset      (rsp_this_offset),
      .rsp_samples_held     (rsp_samples_held)
   );

   initial begin
      forever begin
         #5 clock = ~clock;
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("CHECK FAILED");
      $finish;
   end

   task automatic report_mismatch(input string what, input ts_type got, input ts_type want);
      mismatches++;
      if (mismatches <= MAX_PRINTS)
         $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycle_count);
   endtask

   // inserts one exchange into the ring and returns the filter output it should produce
   function automatic exchange_result_type record_exchange(input ts_type t0, input ts_type t1,
                                                           input ts_type t2, input ts_type t3);
      ts_type              proc_time;
      ts_type              rtt;
      ts_type              leg_out;
      ts_type              leg_back;
      ts_type              off_bits;
      ts_type              top_rtt;
      longint              leg_sum;
      longint              off_val;
      longint              pick_sum;
      longint              avg;
      int                  want;
      int                  picked;
      int                  top_pos;
      int                  i;
      int                  j;
      int                  pick [SLOTS];
      exchange_result_type res;
      proc_time = t2 - t1;
      rtt       = t3 - t0 - proc_time;
      leg_out   = t1 - t0;
      leg_back  = t2 - t3;
      leg_sum   = longint'($signed(leg_out)) + longint'($signed(leg_back));
      off_val   = leg_sum / 2;
      off_bits  = off_val[TS_W-1:0];

      if (ring_count < SLOTS)
         ring_count++;
      ring_rtt[ring_wr] = rtt;
      ring_off[ring_wr] = off_bits;
      ring_wr = (ring_wr + 1) % SLOTS;

      want = ring_count / 4;
      if (want < MIN_PICK)
         want = MIN_PICK;

      // first slots fill the pick, top tracks largest rtt at its first position
      top_rtt  = ring_rtt[0];
      top_pos  = 0;
      pick[0]  = 0;
      picked   = 1;
      pick_sum = longint'($signed(ring_off[0]));
      i = 1;
      while (i < ring_count && picked < want) begin
         pick_sum += longint'($signed(ring_off[i]));
         if (ring_rtt[i] > top_rtt) begin
            top_rtt = ring_rtt[i];
            top_pos = picked;
         end
         pick[picked] = i;
         picked++;
         i++;
      end

      while (i < ring_count) begin
         if (ring_rtt[i] < top_rtt) begin
            pick_sum -= longint'($signed(ring_off[pick[top_pos]]));
            pick_sum += longint'($signed(ring_off[i]));
            pick[top_pos] = i;
            top_rtt = ring_rtt[i];
            for (j = 0; j < picked; j++) begin
               if (ring_rtt[pick[j]] > top_rtt) begin
                  top_rtt = ring_rtt[pick[j]];
                  top_pos = j;
               end
            end
         end
         i++;
      end

      avg = pick_sum / longint'(picked);
      res.estimate   = avg[TS_W-1:0];
      res.round_trip = rtt;
      res.offset     = off_bits;
      res.held       = ring_count[HELD_W-1:0];
      return res;
   endfunction

   // results are checked before the same edge's accepted item is predicted
   always @(posedge clock) begin
      exchange_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("unexpected result", rsp_this_round_trip, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_offset_estimate !== want.estimate)
                  report_mismatch("offset_estimate", rsp_offset_estimate, want.estimate);
               if (rsp_this_round_trip !== want.round_trip)
                  report_mismatch("this_round_trip", rsp_this_round_trip, want.round_trip);
               if (rsp_this_offset !== want.offset)
                  report_mismatch("this_offset", rsp_this_offset, want.offset);
               if (rsp_samples_held !== want.held)
                  report_mismatch("samples_held", ts_type'(rsp_samples_held),
                                  ts_type'(want.held));
            end
         end
         if (req_valid && !req_stall)
            expected_results.push_back(record_exchange(req_ping_sent_local,
               req_ping_seen_remote, req_pong_sent_remote, req_pong_seen_local));
      end
   end

   // receiver stall pattern, with an optional long hold-off
   initial begin
      int hold_left;
      int run_left;
      hold_left = 0;
      run_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (run_left > 0) begin
            run_left--;
         end else begin
            if (rx_busy_pct > 0 && $urandom_range(99) < rx_busy_pct)
               rsp_stall <= 1'b1;
            else
               rsp_stall <= 1'b0;
            if ($urandom_range(19) == 0)
               run_left = $urandom_range(60, 20);
            else
               run_left = $urandom_range(2, 0);
         end
      end
   end

   function automatic int pick_gap();
      if (tx_idle_pct == 0 || $urandom_range(99) >= tx_idle_pct)
         return 0;
      if ($urandom_range(19) == 0)
         return $urandom_range(60, 20);
      return $urandom_range(3, 1);
   endfunction

   task automatic idle_for(input int cycles);
      repeat (cycles) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   task automatic send_sample(input ts_type ping_tx, input ts_type ping_rx,
                              input ts_type pong_tx, input ts_type pong_rx);
      @(negedge clock);
      req_valid            <= 1'b1;
      req_ping_sent_local  <= ping_tx;
      req_ping_seen_remote <= ping_rx;
      req_pong_sent_remote <= pong_tx;
      req_pong_seen_local  <= pong_rx;
      do @(posedge clock); while (req_stall);
   endtask

   // exchange with given network round trip, server processing time and offset
   task automatic send_exchange(input ts_type ping_tx, input ts_type net_rtt,
                                input ts_type proc_time, input ts_type clock_off);
      ts_type out_leg;
      out_leg = $urandom_range(net_rtt);
      send_sample(ping_tx, ping_tx + clock_off + out_leg, ping_tx + clock_off + out_leg + proc_time,
                  ping_tx + out_leg + proc_time + (net_rtt - out_leg));
   endtask

   task automatic wait_drained();
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic test_directed();
      ts_type base;
      int  k;
      tx_idle_pct = 30;
      rx_busy_pct = 30;
      send_sample('0, '0, '0, '0);
      send_sample('1, '1, '1, '1);
      // offset at its positive and negative extremes
      send_sample('0, 32'h7fff_ffff, 32'h7fff_ffff, '0);
      send_sample('0, 32'h8000_0000, 32'h8000_0000, '0);
      // odd leg sums truncate toward zero
      send_sample('0, 32'hffff_ffff, '0, '0);
      send_sample('0, 32'h0000_0001, '0, '0);
      send_sample('0, 32'hffff_fffd, '0, '0);
      send_sample('0, 32'h7fff_ffff, 32'h8000_0000, '0);
      // round trip wraps below zero
      send_sample(32'd5, '0, '0, '0);
      send_sample('0, '0, 32'd1000, 32'd10);
      // equal round trips: pick keeps the first index
      base = 32'hffff_ff00;
      for (k = 0; k < 8; k++) begin
         send_sample(base, base + 32'd7 * k, base + 32'd7 * k, base + 32'd20);
         base = base + 32'd100;
         idle_for(pick_gap());
      end
      send_sample(base, base + 32'd3, base + 32'd3, base + 32'd10);
      send_sample(base, base - 32'd9, base - 32'd9, base + 32'd30);
      send_sample(base, base + 32'd11, base + 32'd11, base + 32'd10);
      idle_for(1);
      wait_drained();
   endtask

   // receiver holds off long enough that the input side must stall
   task automatic test_backpressure();
      int k;
      rx_busy_pct  = 0;
      hold_request = 600;
      for (k = 0; k < 8; k++)
         send_exchange($urandom, $urandom_range(200), $urandom_range(50),
                       $urandom_range(2000) - 1000);
      idle_for(1);
      wait_drained();
   endtask

   task automatic test_random(input int items, input int tx_pct, input int rx_pct);
      ts_type net_rtt;
      ts_type clock_off;
      int  k;
      tx_idle_pct = tx_pct;
      rx_busy_pct = rx_pct;
      for (k = 0; k < items; k++) begin
         if ($urandom_range(99) < 15) begin
            send_sample($urandom, $urandom, $urandom, $urandom);
         end else begin
            // coarse round trips make ties frequent
            if ($urandom_range(2) == 0)
               net_rtt = 5 * $urandom_range(7);
            else
               net_rtt = $urandom_range(300);
            if ($urandom_range(9) == 0)
               clock_off = $urandom;
            else
               clock_off = $urandom_range(2000) - 1000;
            send_exchange($urandom, net_rtt, $urandom_range(100), clock_off);
         end
         idle_for(pick_gap());
      end
      idle_for(1);
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_backpressure();
      test_random(150, 0, 0);
      test_random(620, 40, 40);

      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && expected_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/comrf_pkg.sv
design/comrf_divider.sv
design/comrf_datapath.sv
design/comrf_ctrl.sv
design/clock_offset_min_rtt_filter.sv
design/comrf_checker.sv
tb/tb_clock_offset_min_rtt_filter.sv
